### hdl/assert_macros.svh
// assertion helpers, clocked on clk and disabled in reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define MCF1_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define MCF1_ASSERT_NEXT(lbl, cond, conseq, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
    else $error(msg);

`endif

### hdl/mcf1_pkg.sv
package mcf1_pkg;

  localparam int BITS_W = 16;
  localparam int OP_W   = 2;
  localparam int CFG_W  = 5;
  localparam int SAMP_W = 32;
  localparam int Q_W    = 17;
  localparam int CC_W   = 5;
  localparam int FRAC_STEPS = 16;
  localparam logic [Q_W-1:0] ONE_Q16 = 17'h10000;
  localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

  localparam logic [OP_W-1:0] OP_RECORD = 2'd0;
  localparam logic [OP_W-1:0] OP_REPORT = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  typedef enum logic [1:0] {
    K_RECORD,
    K_REPORT,
    K_CLEAR,
    K_NONE
  } op_kind_t;

  typedef struct packed {
    op_kind_t            kind;
    logic [BITS_W-1:0]   tp_bits;
    logic [BITS_W-1:0]   fp_bits;
    logic [BITS_W-1:0]   fn_bits;
  } queue_entry_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_F1_WAIT,
    S_ERR_MUL,
    S_ERR_DIV,
    S_ERR_WAIT,
    S_MEAN,
    S_MEAN_WAIT,
    S_DONE
  } back_state_t;

  typedef struct packed {
    logic busy;
    logic out_load;
  } back_status_t;

endpackage

### hdl/mcf1_in_if.sv
interface mcf1_in_if;
  logic                          valid;
  logic                          ready;
  logic [mcf1_pkg::OP_W-1:0]     opcode;
  logic [mcf1_pkg::BITS_W-1:0]   truth_bits;
  logic [mcf1_pkg::BITS_W-1:0]   predicted_bits;

  modport source (output valid, output opcode, output truth_bits, output predicted_bits,
                  input ready);
  modport sink (input valid, input opcode, input truth_bits, input predicted_bits,
                output ready);
endinterface

### hdl/mcf1_out_if.sv
interface mcf1_out_if;
  logic                          valid;
  logic                          ready;
  logic [mcf1_pkg::SAMP_W-1:0]   samples_seen;
  logic [mcf1_pkg::Q_W-1:0]      error_rate_frac;
  logic [mcf1_pkg::Q_W-1:0]      macro_f1_frac;
  logic [mcf1_pkg::CC_W-1:0]     classes_counted;

  modport source (output valid, output samples_seen, output error_rate_frac,
                  output macro_f1_frac, output classes_counted, input ready);
  modport sink (input valid, input samples_seen, input error_rate_frac,
                input macro_f1_frac, input classes_counted, output ready);
endinterface

### hdl/mcf1_front.sv
module mcf1_front #(
  parameter int NW = 5
) (
  input  logic                   clk,
  input  logic                   rst_n,
  mcf1_in_if.sink                in_ch,
  input  logic [NW-1:0]          n_cat,
  input  logic                   pop,
  output mcf1_pkg::queue_entry_t head,
  output logic                   head_valid,
  output logic [1:0]             q_count
);

  mcf1_pkg::queue_entry_t entry_r [2];
  logic [1:0] count_r, count_nxt;
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic       push;
  logic [mcf1_pkg::BITS_W-1:0] mask;
  mcf1_pkg::queue_entry_t cls;

  // category mask and classification
  always_comb begin
    for (int i = 0; i < mcf1_pkg::BITS_W; i++) begin
      mask[i] = (32'(i) < 32'(n_cat));
    end
    cls.tp_bits = in_ch.truth_bits & in_ch.predicted_bits & mask;
    cls.fp_bits = ~in_ch.truth_bits & in_ch.predicted_bits & mask;
    cls.fn_bits = in_ch.truth_bits & ~in_ch.predicted_bits & mask;
    unique case (in_ch.opcode)
      mcf1_pkg::OP_RECORD: cls.kind = mcf1_pkg::K_RECORD;
      mcf1_pkg::OP_REPORT: cls.kind = mcf1_pkg::K_REPORT;
      mcf1_pkg::OP_CLEAR:  cls.kind = mcf1_pkg::K_CLEAR;
      mcf1_pkg::OP_UNUSED: cls.kind = mcf1_pkg::K_NONE;
      default:             cls.kind = mcf1_pkg::K_NONE;
    endcase
  end

  assign in_ch.ready = (count_r != 2'd2);
  assign push        = in_ch.valid && in_ch.ready;
  assign head_valid  = (count_r != 2'd0);
  assign head        = entry_r[rd_ptr_r];
  assign q_count     = count_r;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= 2'd0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
    end else begin
      count_r  <= count_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= cls;
    end
  end

endmodule

### hdl/mcf1_div.sv
module mcf1_div #(
  parameter int DW = 41,
  parameter int SW = 23
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic                       frac_mode,
  input  logic [DW-1:0]              num,
  input  logic [DW-1:0]              den,
  output logic                       done,
  output logic [mcf1_pkg::Q_W-1:0]   quo
);

  localparam int CTW = $clog2(SW + 1);

  logic [DW-1:0]  rem_r, rem_nxt;
  logic [DW-1:0]  den_r;
  logic [SW-1:0]  sh_r, sh_nxt;
  logic [CTW-1:0] cnt_r;
  logic           busy_r, done_r;
  logic [DW:0]    rem2;
  logic           ge;

  // one restoring step per cycle
  always_comb begin
    rem2    = {rem_r, sh_r[SW-1]};
    ge      = (rem2 >= {1'b0, den_r});
    rem_nxt = ge ? DW'(rem2 - {1'b0, den_r}) : DW'(rem2);
    sh_nxt  = {sh_r[SW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        den_r <= den;
        if (den == '0) begin
          sh_r   <= '0;
          done_r <= 1'b1;
          busy_r <= 1'b0;
        end else if (frac_mode && (num >= den)) begin
          sh_r   <= SW'(mcf1_pkg::ONE_Q16);
          done_r <= 1'b1;
          busy_r <= 1'b0;
        end else begin
          rem_r  <= frac_mode ? num : '0;
          sh_r   <= frac_mode ? '0 : num[SW-1:0];
          cnt_r  <= frac_mode ? CTW'(mcf1_pkg::FRAC_STEPS) : CTW'(SW);
          busy_r <= 1'b1;
        end
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        sh_r  <= sh_nxt;
        cnt_r <= cnt_r - CTW'(1);
        if (cnt_r == CTW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = sh_r[mcf1_pkg::Q_W-1:0];

endmodule

### hdl/mcf1_back.sv
module mcf1_back #(
  parameter int MAX_CATEGORIES = 16,
  parameter int CW = 32,
  parameter int NW = 5,
  parameter int DW = 41,
  parameter int SW = 23
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [NW-1:0]          n_cat,
  input  mcf1_pkg::queue_entry_t head,
  input  logic                   head_valid,
  output logic                   pop,
  mcf1_out_if.source             out_ch,
  output mcf1_pkg::back_status_t status
);

  localparam int IW = (MAX_CATEGORIES > 1) ? $clog2(MAX_CATEGORIES) : 1;
  localparam int XW = (CW > mcf1_pkg::SAMP_W) ? CW : mcf1_pkg::SAMP_W;
  localparam int BW = mcf1_pkg::BITS_W;

  logic [CW-1:0] tp_r [MAX_CATEGORIES];
  logic [CW-1:0] fp_r [MAX_CATEGORIES];
  logic [CW-1:0] fn_r [MAX_CATEGORIES];
  logic [CW-1:0] sample_r;

  mcf1_pkg::back_state_t state_r, state_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic [DW-1:0] err_sum_r, err_sum_nxt;
  logic [SW-1:0] f1_sum_r, f1_sum_nxt;
  logic [NW-1:0] counted_r, counted_nxt;
  logic [DW-1:0] prod_r, prod_nxt;
  logic [mcf1_pkg::Q_W-1:0] err_q_r, err_q_nxt;
  logic [mcf1_pkg::Q_W-1:0] f1_q_r, f1_q_nxt;

  logic                        out_valid_r, out_valid_nxt;
  logic [mcf1_pkg::SAMP_W-1:0] out_samp_r;
  logic [mcf1_pkg::Q_W-1:0]    out_err_r, out_f1_r;
  logic [mcf1_pkg::CC_W-1:0]   out_cc_r;
  logic                        load;
  logic [mcf1_pkg::SAMP_W-1:0] load_samp;
  logic [mcf1_pkg::Q_W-1:0]    load_err, load_f1;
  logic [mcf1_pkg::CC_W-1:0]   load_cc;

  logic do_record, do_clear, slot_free, last, act;
  logic [CW-1:0] sample_inc, cur_tp, cur_fp, cur_fn;
  logic [XW-1:0] s_ext, si_ext;
  logic [MAX_CATEGORIES+BW-1:0] tp_ext, fp_ext, fn_ext;

  logic                        div_start, div_frac, div_done;
  logic [DW-1:0]               div_num, div_den;
  logic [mcf1_pkg::Q_W-1:0]    div_quo;

  mcf1_div #(.DW(DW), .SW(SW)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .frac_mode (div_frac),
    .num       (div_num),
    .den       (div_den),
    .done      (div_done),
    .quo       (div_quo)
  );

  assign sample_inc = (&sample_r) ? sample_r : sample_r + CW'(1);
  assign s_ext      = XW'(sample_r);
  assign si_ext     = XW'(sample_inc);
  assign slot_free  = !out_valid_r || out_ch.ready;
  assign cur_tp     = tp_r[idx_r];
  assign cur_fp     = fp_r[idx_r];
  assign cur_fn     = fn_r[idx_r];
  assign act        = |(cur_tp | cur_fp | cur_fn);
  assign last       = (32'(idx_r) + 32'd1 >= 32'(n_cat));
  assign tp_ext     = {{MAX_CATEGORIES{1'b0}}, head.tp_bits};
  assign fp_ext     = {{MAX_CATEGORIES{1'b0}}, head.fp_bits};
  assign fn_ext     = {{MAX_CATEGORIES{1'b0}}, head.fn_bits};

  always_comb begin
    state_nxt   = state_r;
    idx_nxt     = idx_r;
    err_sum_nxt = err_sum_r;
    f1_sum_nxt  = f1_sum_r;
    counted_nxt = counted_r;
    prod_nxt    = prod_r;
    err_q_nxt   = err_q_r;
    f1_q_nxt    = f1_q_r;
    pop         = 1'b0;
    do_record   = 1'b0;
    do_clear    = 1'b0;
    load        = 1'b0;
    load_samp   = (s_ext > XW'(32'hFFFFFFFF)) ? '1 : s_ext[mcf1_pkg::SAMP_W-1:0];
    load_err    = '0;
    load_f1     = '0;
    load_cc     = '0;
    div_start   = 1'b0;
    div_frac    = 1'b1;
    div_num     = DW'({cur_tp, 1'b0});
    div_den     = DW'({cur_tp, 1'b0}) + DW'(cur_fp) + DW'(cur_fn);
    unique case (state_r)
      mcf1_pkg::S_IDLE: begin
        if (head_valid && slot_free) begin
          pop = 1'b1;
          unique case (head.kind)
            mcf1_pkg::K_RECORD: begin
              do_record = 1'b1;
              load      = 1'b1;
              load_samp = (si_ext > XW'(32'hFFFFFFFF)) ? '1
                                                       : si_ext[mcf1_pkg::SAMP_W-1:0];
            end
            mcf1_pkg::K_CLEAR: begin
              do_clear  = 1'b1;
              load      = 1'b1;
              load_samp = '0;
            end
            mcf1_pkg::K_NONE: begin
              load = 1'b1;
            end
            mcf1_pkg::K_REPORT: begin
              idx_nxt     = '0;
              err_sum_nxt = '0;
              f1_sum_nxt  = '0;
              counted_nxt = '0;
              state_nxt   = mcf1_pkg::S_SCAN;
            end
            default: ;
          endcase
        end
      end
      mcf1_pkg::S_SCAN: begin
        err_sum_nxt = err_sum_r + DW'(cur_fp) + DW'(cur_fn);
        if (act) begin
          div_start   = 1'b1;
          counted_nxt = counted_r + NW'(1);
          state_nxt   = mcf1_pkg::S_F1_WAIT;
        end else if (last) begin
          state_nxt = mcf1_pkg::S_ERR_MUL;
        end else begin
          idx_nxt = idx_r + IW'(1);
        end
      end
      mcf1_pkg::S_F1_WAIT: begin
        if (div_done) begin
          f1_sum_nxt = f1_sum_r + SW'(div_quo);
          if (last) begin
            state_nxt = mcf1_pkg::S_ERR_MUL;
          end else begin
            idx_nxt   = idx_r + IW'(1);
            state_nxt = mcf1_pkg::S_SCAN;
          end
        end
      end
      mcf1_pkg::S_ERR_MUL: begin
        prod_nxt  = DW'(DW'(n_cat) * DW'(sample_r));
        state_nxt = mcf1_pkg::S_ERR_DIV;
      end
      mcf1_pkg::S_ERR_DIV: begin
        div_start = 1'b1;
        div_num   = err_sum_r;
        div_den   = prod_r;
        state_nxt = mcf1_pkg::S_ERR_WAIT;
      end
      mcf1_pkg::S_ERR_WAIT: begin
        if (div_done) begin
          err_q_nxt = div_quo;
          state_nxt = mcf1_pkg::S_MEAN;
        end
      end
      mcf1_pkg::S_MEAN: begin
        if (counted_r == '0) begin
          f1_q_nxt  = '0;
          state_nxt = mcf1_pkg::S_DONE;
        end else begin
          div_start = 1'b1;
          div_frac  = 1'b0;
          div_num   = DW'(f1_sum_r);
          div_den   = DW'(counted_r);
          state_nxt = mcf1_pkg::S_MEAN_WAIT;
        end
      end
      mcf1_pkg::S_MEAN_WAIT: begin
        if (div_done) begin
          f1_q_nxt  = div_quo;
          state_nxt = mcf1_pkg::S_DONE;
        end
      end
      mcf1_pkg::S_DONE: begin
        if (slot_free) begin
          load      = 1'b1;
          load_err  = err_q_r;
          load_f1   = f1_q_r;
          load_cc   = mcf1_pkg::CC_W'(counted_r);
          state_nxt = mcf1_pkg::S_IDLE;
        end
      end
      default: state_nxt = mcf1_pkg::S_IDLE;
    endcase
    out_valid_nxt = (out_valid_r && !out_ch.ready) || load;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mcf1_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r     <= idx_nxt;
    err_sum_r <= err_sum_nxt;
    f1_sum_r  <= f1_sum_nxt;
    counted_r <= counted_nxt;
    prod_r    <= prod_nxt;
    err_q_r   <= err_q_nxt;
    f1_q_r    <= f1_q_nxt;
    if (load) begin
      out_samp_r <= load_samp;
      out_err_r  <= load_err;
      out_f1_r   <= load_f1;
      out_cc_r   <= load_cc;
    end
  end

  // saturating counters, all categories in parallel
  always_ff @(posedge clk) begin
    if (!rst_n || do_clear) begin
      sample_r <= '0;
      for (int i = 0; i < MAX_CATEGORIES; i++) begin
        tp_r[i] <= '0;
        fp_r[i] <= '0;
        fn_r[i] <= '0;
      end
    end else if (do_record) begin
      sample_r <= sample_inc;
      for (int i = 0; i < MAX_CATEGORIES; i++) begin
        if (tp_ext[i] && !(&tp_r[i])) tp_r[i] <= tp_r[i] + CW'(1);
        if (fp_ext[i] && !(&fp_r[i])) fp_r[i] <= fp_r[i] + CW'(1);
        if (fn_ext[i] && !(&fn_r[i])) fn_r[i] <= fn_r[i] + CW'(1);
      end
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.samples_seen    = out_samp_r;
  assign out_ch.error_rate_frac = out_err_r;
  assign out_ch.macro_f1_frac   = out_f1_r;
  assign out_ch.classes_counted = out_cc_r;
  assign status.busy            = (state_r != mcf1_pkg::S_IDLE);
  assign status.out_load        = load;

endmodule

### hdl/multilabel_confusion_f1_accumulator.sv
// Multilabel confusion counters with error-rate and macro F1 report.
// in_ch carries opcode, truth_bits and predicted_bits; out_ch returns one
// transaction per input transaction: samples_seen, error_rate_frac,
// macro_f1_frac and classes_counted. cfg_we/cfg_data set the number of
// categories in use; the user must write them only while the block is
// idle, which it does not enforce. A front stage classifies each
// transaction into per-category TP/FP/FN bits and queues it in a
// two-entry queue; the back stage owns the counters. Record, clear and
// unused opcodes run in the back stage's idle state, one transaction per
// cycle while out_ch is not stalled, each through a queue entry and then
// the result register. A report walks the categories, using one shared
// restoring divider for active ones, then the error rate and the mean F1.
// Reset clears all counters at once and sets 16 categories in use.
// While out_ch is stalled the result register holds, the queue keeps
// accepting until both entries are full, then in_ch.ready drops.
`include "assert_macros.svh"

module multilabel_confusion_f1_accumulator #(
  parameter int MAX_CATEGORIES = 16,
  parameter int COUNT_WIDTH = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  mcf1_in_if.sink                     in_ch,
  mcf1_out_if.source                  out_ch,
  input  logic                        cfg_we,
  input  logic [mcf1_pkg::CFG_W-1:0]  cfg_data
);

  localparam int NW   = $clog2(MAX_CATEGORIES + 1);
  localparam int SW   = mcf1_pkg::Q_W + NW + 1;
  localparam int BASE = COUNT_WIDTH + NW + 1;
  localparam int DW   = (BASE > SW) ? BASE : SW;

  logic [mcf1_pkg::CFG_W-1:0] cat_r;
  logic [NW-1:0]              n_cat;
  mcf1_pkg::queue_entry_t     head;
  logic                       head_valid, pop;
  logic [1:0]                 q_count;
  mcf1_pkg::back_status_t     status;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cat_r <= mcf1_pkg::CFG_RESET;
    end else if (cfg_we) begin
      cat_r <= cfg_data;
    end
  end

  always_comb begin
    priority if (cat_r == '0) begin
      n_cat = NW'(1);
    end else if (32'(cat_r) > 32'(MAX_CATEGORIES)) begin
      n_cat = NW'(MAX_CATEGORIES);
    end else begin
      n_cat = NW'(cat_r);
    end
  end

  mcf1_front #(.NW(NW)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .n_cat      (n_cat),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid),
    .q_count    (q_count)
  );

  mcf1_back #(
    .MAX_CATEGORIES (MAX_CATEGORIES),
    .CW             (COUNT_WIDTH),
    .NW             (NW),
    .DW             (DW),
    .SW             (SW)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .n_cat      (n_cat),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .out_ch     (out_ch),
    .status     (status)
  );

  // a stalled result is never overwritten
  `MCF1_ASSERT(a_no_overwrite, (out_ch.valid && !out_ch.ready) |-> !status.out_load, "result overwritten while stalled")
  // an accepted transaction is held in the queue
  `MCF1_ASSERT_NEXT(a_push_held, in_ch.valid && in_ch.ready, q_count != 2'd0, "accepted transaction lost")
  // a report in progress pops no queue entry until it finishes
  `MCF1_ASSERT(a_busy_no_pop, status.busy |-> !pop, "queue popped during report")

endmodule

### tb/tb.sv
module tb;

  typedef struct packed {
    logic [mcf1_pkg::SAMP_W-1:0] samples;
    logic [mcf1_pkg::Q_W-1:0]    err;
    logic [mcf1_pkg::Q_W-1:0]    f1;
    logic [mcf1_pkg::CC_W-1:0]   counted;
  } metrics_t;

  typedef struct {
    logic [mcf1_pkg::OP_W-1:0]   op;
    logic [mcf1_pkg::BITS_W-1:0] truth;
    logic [mcf1_pkg::BITS_W-1:0] pred;
    bit                          typed;
    metrics_t                    res;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [mcf1_pkg::CFG_W-1:0] cfg_data = '0;

  mcf1_in_if in_ch ();
  mcf1_out_if out_ch ();

  multilabel_confusion_f1_accumulator u_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  logic [31:0] tp_cnt [16];
  logic [31:0] fp_cnt [16];
  logic [31:0] fn_cnt [16];
  logic [31:0] sample_cnt;
  logic [mcf1_pkg::CFG_W-1:0] cat_reg;
  metrics_t pending_metrics [$];
  int errors_seen = 0;
  bit quiet = 1'b0;
  int ready_hold = 0;

  function automatic logic [31:0] bump(logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  function automatic logic [63:0] q16_div(logic [63:0] num, logic [63:0] den);
    logic [63:0] rem;
    logic [63:0] q;
    rem = num;
    q = 0;
    if (den == 0) return 0;
    if (num >= den) return 64'h10000;
    for (int k = 0; k < mcf1_pkg::FRAC_STEPS; k++) begin
      rem = rem << 1;
      q = q << 1;
      if (rem >= den) begin
        rem = rem - den;
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic metrics_t predict_metrics(logic [mcf1_pkg::OP_W-1:0] op,
                                               logic [mcf1_pkg::BITS_W-1:0] t,
                                               logic [mcf1_pkg::BITS_W-1:0] p);
    metrics_t r;
    int n;
    logic [63:0] errs, f1_sum, cnt, tp, fp, fn;
    r = '0;
    errs = 0;
    f1_sum = 0;
    cnt = 0;
    n = (cat_reg == 0) ? 1 : (cat_reg > 16) ? 16 : int'(cat_reg);
    if (op == mcf1_pkg::OP_RECORD) begin
      for (int i = 0; i < n; i++) begin
        if (t[i] && p[i]) tp_cnt[i] = bump(tp_cnt[i]);
        else if (!t[i] && p[i]) fp_cnt[i] = bump(fp_cnt[i]);
        else if (t[i] && !p[i]) fn_cnt[i] = bump(fn_cnt[i]);
      end
      sample_cnt = bump(sample_cnt);
    end else if (op == mcf1_pkg::OP_REPORT) begin
      for (int i = 0; i < n; i++) begin
        tp = tp_cnt[i];
        fp = fp_cnt[i];
        fn = fn_cnt[i];
        errs += fp + fn;
        if (tp + fp + fn != 0) begin
          f1_sum += q16_div(2 * tp, 2 * tp + fp + fn);
          cnt++;
        end
      end
      r.err = mcf1_pkg::Q_W'(q16_div(errs, 64'(n) * 64'(sample_cnt)));
      r.f1 = (cnt == 0) ? '0 : mcf1_pkg::Q_W'(f1_sum / cnt);
      r.counted = mcf1_pkg::CC_W'(cnt);
    end else if (op == mcf1_pkg::OP_CLEAR) begin
      for (int i = 0; i < 16; i++) begin
        tp_cnt[i] = 0;
        fp_cnt[i] = 0;
        fn_cnt[i] = 0;
      end
      sample_cnt = 0;
    end
    r.samples = sample_cnt;
    return r;
  endfunction

  task automatic send_item(logic [mcf1_pkg::OP_W-1:0] op, logic [mcf1_pkg::BITS_W-1:0] t,
                           logic [mcf1_pkg::BITS_W-1:0] p, bit typed, metrics_t typed_res);
    metrics_t m;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.opcode <= op;
    in_ch.truth_bits <= t;
    in_ch.predicted_bits <= p;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    m = predict_metrics(op, t, p);
    pending_metrics.push_back(typed ? typed_res : m);
  endtask

  task automatic write_categories(logic [mcf1_pkg::CFG_W-1:0] v);
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_metrics.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cat_reg = v;
    cfg_we <= 1'b0;
  endtask

  task automatic random_item();
    int sel;
    logic [mcf1_pkg::OP_W-1:0] op;
    logic [mcf1_pkg::BITS_W-1:0] t, p;
    sel = $urandom_range(0, 99);
    op = (sel < 88) ? mcf1_pkg::OP_RECORD : (sel < 94) ? mcf1_pkg::OP_REPORT :
         (sel < 97) ? mcf1_pkg::OP_CLEAR : mcf1_pkg::OP_UNUSED;
    t = mcf1_pkg::BITS_W'($urandom);
    p = ($urandom_range(0, 1) == 0) ? t ^ mcf1_pkg::BITS_W'($urandom & $urandom)
                                    : mcf1_pkg::BITS_W'($urandom);
    send_item(op, t, p, 1'b0, '0);
  endtask

  always @(posedge clk) begin
    if (ready_hold == 0) begin
      out_ch.ready <= quiet || ($urandom_range(0, 2) != 0);
      ready_hold <= quiet ? 1 : $urandom_range(1, 16);
    end else begin
      ready_hold <= ready_hold - 1;
    end
  end

  always @(posedge clk) begin
    metrics_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_metrics.size() == 0) begin
        $error("unexpected transaction samples_seen=%0d", out_ch.samples_seen);
        errors_seen++;
      end else begin
        e = pending_metrics.pop_front();
        if (out_ch.samples_seen !== e.samples) begin
          $error("samples_seen exp %0d got %0d", e.samples, out_ch.samples_seen);
          errors_seen++;
        end
        if (out_ch.error_rate_frac !== e.err) begin
          $error("error_rate_frac exp %0d got %0d", e.err, out_ch.error_rate_frac);
          errors_seen++;
        end
        if (out_ch.macro_f1_frac !== e.f1) begin
          $error("macro_f1_frac exp %0d got %0d", e.f1, out_ch.macro_f1_frac);
          errors_seen++;
        end
        if (out_ch.classes_counted !== e.counted) begin
          $error("classes_counted exp %0d got %0d", e.counted, out_ch.classes_counted);
          errors_seen++;
        end
      end
    end
  end

  initial begin
    #4000000;
    $display("FAIL multilabel_confusion_f1_accumulator");
    $finish;
  end

  initial begin
    stim_row_t rows [$];
    logic [mcf1_pkg::CFG_W-1:0] cfg_list [8];
    in_ch.valid = 1'b0;
    in_ch.opcode = mcf1_pkg::OP_RECORD;
    in_ch.truth_bits = '0;
    in_ch.predicted_bits = '0;
    out_ch.ready = 1'b0;
    for (int i = 0; i < 16; i++) begin
      tp_cnt[i] = 0;
      fp_cnt[i] = 0;
      fn_cnt[i] = 0;
    end
    sample_cnt = 0;
    cat_reg = mcf1_pkg::CFG_RESET;
    rows = '{
      '{mcf1_pkg::OP_REPORT, 16'h0000, 16'h0000, 1'b1, '{32'd0, 17'd0, 17'd0, 5'd0}},
      '{mcf1_pkg::OP_UNUSED, 16'hFFFF, 16'hFFFF, 1'b1, '{32'd0, 17'd0, 17'd0, 5'd0}},
      '{mcf1_pkg::OP_RECORD, 16'hFFFF, 16'hFFFF, 1'b1, '{32'd1, 17'd0, 17'd0, 5'd0}},
      '{mcf1_pkg::OP_REPORT, 16'h0000, 16'h0000, 1'b1, '{32'd1, 17'd0, 17'h10000, 5'd16}},
      '{mcf1_pkg::OP_RECORD, 16'h0000, 16'hFFFF, 1'b1, '{32'd2, 17'd0, 17'd0, 5'd0}},
      '{mcf1_pkg::OP_REPORT, 16'h0000, 16'h0000, 1'b1, '{32'd2, 17'd32768, 17'd43690, 5'd16}},
      '{mcf1_pkg::OP_CLEAR,  16'hFFFF, 16'h0000, 1'b1, '{32'd0, 17'd0, 17'd0, 5'd0}},
      '{mcf1_pkg::OP_REPORT, 16'h0000, 16'h0000, 1'b1, '{32'd0, 17'd0, 17'd0, 5'd0}},
      '{mcf1_pkg::OP_RECORD, 16'hFFFF, 16'h0000, 1'b0, '0},
      '{mcf1_pkg::OP_RECORD, 16'h5555, 16'hAAAA, 1'b0, '0},
      '{mcf1_pkg::OP_RECORD, 16'h00FF, 16'h0F0F, 1'b0, '0},
      '{mcf1_pkg::OP_RECORD, 16'h0000, 16'h0000, 1'b0, '0},
      '{mcf1_pkg::OP_REPORT, 16'h0000, 16'h0000, 1'b0, '0},
      '{mcf1_pkg::OP_UNUSED, 16'h1234, 16'h4321, 1'b0, '0},
      '{mcf1_pkg::OP_RECORD, 16'h8001, 16'h8000, 1'b0, '0},
      '{mcf1_pkg::OP_REPORT, 16'hFFFF, 16'hFFFF, 1'b0, '0}
    };
    cfg_list = '{5'd1, 5'd0, 5'd31, 5'd16, 5'd17, 5'd8, 5'd3, 5'd12};
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (rows[i]) send_item(rows[i].op, rows[i].truth, rows[i].pred, rows[i].typed,
                                rows[i].res);
    foreach (cfg_list[c]) begin
      write_categories(cfg_list[c]);
      send_item(mcf1_pkg::OP_REPORT, '0, '0, 1'b0, '0);
      for (int k = 0; k < 140; k++) random_item();
      send_item(mcf1_pkg::OP_REPORT, '0, '0, 1'b0, '0);
    end
    write_categories(mcf1_pkg::CFG_W'($urandom_range(1, 16)));
    quiet = 1'b1;
    for (int k = 0; k < 150; k++) random_item();
    send_item(mcf1_pkg::OP_REPORT, '0, '0, 1'b0, '0);
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_metrics.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors_seen == 0) begin
      $display("PASS multilabel_confusion_f1_accumulator");
    end else begin
      $display("FAIL multilabel_confusion_f1_accumulator");
    end
    $finish;
  end
endmodule

### multilabel_confusion_f1_accumulator.f
+incdir+hdl
hdl/mcf1_pkg.sv
hdl/mcf1_in_if.sv
hdl/mcf1_out_if.sv
hdl/mcf1_front.sv
hdl/mcf1_div.sv
hdl/mcf1_back.sv
hdl/multilabel_confusion_f1_accumulator.sv
tb/tb.sv
